// File: sv/llf_pkg.sv
// Shared types for the least-laxity-first scheduler core.
// Holds the controller state, command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package llf_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAX,
    S_ZCHK,
    S_SORT1,
    S_RUN,
    S_SORT2,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic arrive;
    logic start_tick;
    logic lax;
    logic phase_en;
    logic phase_odd;
    logic run;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic any_zero;
    logic finished;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// File: sv/llf_if.sv
// Valid/ready channel interfaces for the scheduler input and result words.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface llf_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  job_id;
  logic [15:0] deadline;
  logic [15:0] service_time;
  modport source (output valid, action, job_id, deadline, service_time, input ready);
  modport sink (input valid, action, job_id, deadline, service_time, output ready);
endinterface

interface llf_out_if;
  logic        valid;
  logic        ready;
  logic        ran_valid;
  logic [7:0]  ran_job;
  logic        job_finished;
  logic [15:0] tick_time;
  logic        overflow_seen;
  modport source (output valid, ran_valid, ran_job, job_finished, tick_time,
                  overflow_seen, input ready);
  modport sink (input valid, ran_valid, ran_job, job_finished, tick_time,
                overflow_seen, output ready);
endinterface
`default_nettype wire

// File: sv/llf_datapath.sv
// Datapath: job queue registers, laxity compute, odd-even sort network,
// time counter and result register. Depends on llf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module llf_datapath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire llf_pkg::cmd_t  cmd,
  output llf_pkg::stat_t      stat,
  input  wire logic [7:0]     in_job_id,
  input  wire logic [15:0]    in_deadline,
  input  wire logic [15:0]    in_service_time,
  input  wire logic           out_ready,
  output logic                out_valid,
  output logic                out_ran_valid,
  output logic [7:0]          out_ran_job,
  output logic                out_job_finished,
  output logic [15:0]         out_tick_time,
  output logic                out_overflow_seen
);
  import llf_pkg::*;

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [7:0]         id_r   [QUEUE_DEPTH];
  logic [15:0]        dl_r   [QUEUE_DEPTH];
  logic [15:0]        rem_r  [QUEUE_DEPTH];
  logic signed [17:0] lax_r  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] zero_r;
  logic [CW-1:0]      count_r;
  logic [15:0]        time_r;
  logic               ovf_r;
  logic               ran_valid_r, finished_r;
  logic [7:0]         ran_job_r;
  logic               out_valid_r;
  logic signed [17:0] lax_nxt [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] zero_nxt;
  logic [QUEUE_DEPTH-1:0] swap;

  // Laxity of every entry against the current time, and its zero flag.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      lax_nxt[i] = $signed({2'b00, dl_r[i]}) - $signed({2'b00, rem_r[i]})
                   - $signed({2'b00, time_r});
      zero_nxt[i] = (lax_nxt[i] == 18'sd0) && (CW'(i) < count_r);
    end
  end

  // Compare-exchange pairs of the current sort phase; strict compare keeps it stable.
  always_comb begin
    swap = '0;
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      swap[i] = cmd.phase_en && ((i % 2) == int'(cmd.phase_odd))
                && (CW'(i + 1) < count_r) && (lax_r[i] > lax_r[i + 1]);
    end
  end

  // Queue entry storage.
  always_ff @(posedge clk) begin
    if (cmd.arrive && (count_r < CW'(QUEUE_DEPTH))) begin
      id_r[count_r[IW-1:0]]  <= in_job_id;
      dl_r[count_r[IW-1:0]]  <= in_deadline;
      rem_r[count_r[IW-1:0]] <= in_service_time;
    end
    if (cmd.lax) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) lax_r[i] <= lax_nxt[i];
      zero_r <= zero_nxt;
    end
    // Pairs of one phase never overlap, so each pair exchanges on its own.
    if (cmd.phase_en) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        if (swap[i]) begin
          id_r[i] <= id_r[i + 1]; dl_r[i] <= dl_r[i + 1];
          rem_r[i] <= rem_r[i + 1]; lax_r[i] <= lax_r[i + 1];
          id_r[i + 1] <= id_r[i]; dl_r[i + 1] <= dl_r[i];
          rem_r[i + 1] <= rem_r[i]; lax_r[i + 1] <= lax_r[i];
        end
      end
    end
    if (cmd.run) begin
      if (stat.finished) begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          id_r[i] <= id_r[i + 1]; dl_r[i] <= dl_r[i + 1];
          rem_r[i] <= rem_r[i + 1]; lax_r[i] <= lax_r[i + 1];
        end
      end else begin
        rem_r[0] <= rem_r[0] - 16'd1;
      end
    end
    if (cmd.start_tick) begin
      ran_valid_r <= 1'b0;
      ran_job_r   <= 8'd0;
      finished_r  <= 1'b0;
    end else if (cmd.run) begin
      ran_valid_r <= 1'b1;
      ran_job_r   <= id_r[0];
      finished_r  <= stat.finished;
    end
  end

  // Control registers: count, time, overflow flag, result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      time_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.arrive) begin
        if (count_r < CW'(QUEUE_DEPTH)) count_r <= count_r + CW'(1);
        else ovf_r <= 1'b1;
      end
      if (cmd.run && stat.finished) count_r <= count_r - CW'(1);
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
        if (time_r != 16'hFFFF) time_r <= time_r + 16'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result word register, loaded once per tick.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ran_valid     <= ran_valid_r;
      out_ran_job       <= ran_job_r;
      out_job_finished  <= finished_r;
      out_tick_time     <= time_r;
      out_overflow_seen <= ovf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign stat.empty     = (count_r == '0);
  assign stat.any_zero  = |zero_r;
  assign stat.finished  = (rem_r[0] <= 16'd1);
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule
`default_nettype wire

// File: sv/llf_ctrl.sv
// Controller state machine sequencing arrivals and the tick steps.
// Depends on llf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module llf_ctrl #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_action,
  output logic                 in_ready,
  input  wire llf_pkg::stat_t  stat,
  output llf_pkg::cmd_t        cmd
);
  import llf_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH + 1);

  state_t        state_r, state_nxt;
  logic [PW-1:0] phase_r, phase_nxt;
  logic          phase_done;

  assign phase_done = (phase_r == PW'(QUEUE_DEPTH - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid && in_action) state_nxt = stat.empty ? S_OUT : S_LAX;
      S_LAX:   state_nxt = S_ZCHK;
      S_ZCHK:  state_nxt = stat.any_zero ? S_SORT1 : S_RUN;
      S_SORT1: if (phase_done) state_nxt = S_RUN;
      S_RUN:   state_nxt = stat.finished ? S_SORT2 : S_OUT;
      S_SORT2: if (phase_done) state_nxt = S_OUT;
      S_OUT:   if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sort phase counter.
  always_comb begin
    phase_nxt = '0;
    if ((state_r == S_SORT1 || state_r == S_SORT2) && !phase_done)
      phase_nxt = phase_r + PW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.arrive = in_valid && !in_action;
        cmd.start_tick = in_valid && in_action;
      end
      S_LAX:   cmd.lax = 1'b1;
      S_SORT1, S_SORT2: begin
        cmd.phase_en = 1'b1;
        cmd.phase_odd = phase_r[0];
      end
      S_RUN:   cmd.run = 1'b1;
      S_OUT:   cmd.load_out = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/least_laxity_first_scheduler_core.sv
// Top level of the least-laxity-first scheduler: controller plus datapath.
// Depends on llf_pkg, llf_if, llf_ctrl and llf_datapath.
//
//   channel  dir  modport  word
//   in_ch    in   sink     action, job_id, deadline, service_time
//   out_ch   out  source   ran_valid, ran_job, job_finished, tick_time, overflow_seen
//
// An arrival is taken in the idle step. A tick on an empty queue only loads the
// result; else it computes laxities, runs the head job and loads the result, with
// an odd-even sort pass before the run if any laxity is zero, after it if it finishes.
// rst_n is synchronous; the queue entries themselves are not reset.
// A stalled result holds the block in its output step until taken.
`timescale 1ns / 1ps
`default_nettype none
module least_laxity_first_scheduler_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  llf_in_if.sink    in_ch,
  llf_out_if.source out_ch
);
  import llf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  llf_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_action(in_ch.action), .in_ready(in_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  llf_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_job_id(in_ch.job_id), .in_deadline(in_ch.deadline),
    .in_service_time(in_ch.service_time),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .out_ran_valid(out_ch.ran_valid), .out_ran_job(out_ch.ran_job),
    .out_job_finished(out_ch.job_finished), .out_tick_time(out_ch.tick_time),
    .out_overflow_seen(out_ch.overflow_seen)
  );

  // Only one datapath step is commanded in any cycle.
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.arrive, cmd.start_tick, cmd.lax, cmd.phase_en, cmd.run, cmd.load_out}))
    else $error("more than one datapath step commanded");

  // A job never runs on an empty queue.
  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run |-> !stat.empty)
    else $error("run commanded on empty queue");

  // After a tick is accepted the input is closed until its result is loaded.
  a_tick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_tick |=> !in_ch.ready)
    else $error("input open during tick");

  // A result is only loaded when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded over a pending word");

endmodule
`default_nettype wire

// File: tb/least_laxity_first_scheduler_core_tb.sv
// Testbench for the least-laxity-first scheduler core: random and directed words
// checked against a scoreboard predictor. Depends on llf_pkg, llf_if and the core.
`timescale 1ns / 1ps
module least_laxity_first_scheduler_core_tb;
  localparam int DEPTH = 16;

  typedef struct packed {
    logic        action;
    logic [7:0]  job_id;
    logic [15:0] deadline;
    logic [15:0] service_time;
  } job_word_t;

  typedef struct packed {
    logic        ran_valid;
    logic [7:0]  ran_job;
    logic        job_finished;
    logic [15:0] tick_time;
    logic        overflow_seen;
  } tick_word_t;

  localparam logic ACT_ARRIVE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  logic clk;
  logic rst_n;
  llf_in_if in_ch();
  llf_out_if out_ch();

  least_laxity_first_scheduler_core #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Shadow copy of the job queue.
  logic [7:0]  q_id [DEPTH];
  logic [15:0] q_dl [DEPTH];
  logic [15:0] q_rem [DEPTH];
  int          q_lax [DEPTH];
  int          q_len;
  logic [15:0] sched_time;
  logic        dropped_flag;

  job_word_t  pending_jobs[$];
  tick_word_t expected_ticks[$];
  int mismatches;
  bit send_idle_on;
  bit recv_idle_on;
  int hold_cycles;
  int send_gap;
  int recv_gap;
  bit send_pause;

  // Append one word to the tail of the pending queue.
  task automatic queue_job(input job_word_t w);
    pending_jobs = {pending_jobs, w};
  endtask

  // Stable insertion sort by laxity.
  task automatic order_by_laxity();
    logic [7:0] id; logic [15:0] dl, rm; int lx, j;
    for (int i = 1; i < q_len; i++) begin
      id = q_id[i]; dl = q_dl[i]; rm = q_rem[i]; lx = q_lax[i]; j = i;
      while (j > 0 && q_lax[j-1] > lx) begin
        q_id[j] = q_id[j-1]; q_dl[j] = q_dl[j-1];
        q_rem[j] = q_rem[j-1]; q_lax[j] = q_lax[j-1];
        j--;
      end
      q_id[j] = id; q_dl[j] = dl; q_rem[j] = rm; q_lax[j] = lx;
    end
  endtask

  // Apply one accepted word to the shadow queue and queue its expected tick report.
  task automatic schedule_word(input job_word_t w);
    tick_word_t r; bit any_zero;
    if (w.action == ACT_ARRIVE) begin
      if (q_len >= DEPTH) dropped_flag = 1'b1;
      else begin
        q_id[q_len] = w.job_id; q_dl[q_len] = w.deadline;
        q_rem[q_len] = w.service_time; q_lax[q_len] = 0; q_len++;
      end
      return;
    end
    r = '0; r.tick_time = sched_time; r.overflow_seen = dropped_flag;
    any_zero = 1'b0;
    if (q_len > 0) begin
      for (int i = 0; i < q_len; i++) begin
        q_lax[i] = int'(q_dl[i]) - int'(q_rem[i]) - int'(sched_time);
        if (q_lax[i] == 0) any_zero = 1'b1;
      end
      if (any_zero) order_by_laxity();
      r.ran_valid = 1'b1; r.ran_job = q_id[0];
      if (q_rem[0] <= 1) begin
        r.job_finished = 1'b1;
        for (int i = 1; i < q_len; i++) begin
          q_id[i-1] = q_id[i]; q_dl[i-1] = q_dl[i];
          q_rem[i-1] = q_rem[i]; q_lax[i-1] = q_lax[i];
        end
        q_len--;
        order_by_laxity();
      end else q_rem[0] = q_rem[0] - 16'd1;
    end
    if (sched_time != 16'hFFFF) sched_time = sched_time + 16'd1;
    expected_ticks = {expected_ticks, r};
  endtask

  function automatic job_word_t make_job(logic [7:0] id, logic [15:0] dl, logic [15:0] st);
    make_job = '{ACT_ARRIVE, id, dl, st};
  endfunction

  function automatic job_word_t make_tick();
    make_tick = '{ACT_TICK, 8'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Driver: offers the next pending word, with random idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        schedule_word(pending_jobs.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the offered word.
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (send_pause || pending_jobs.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (send_idle_on && $urandom_range(0, 5) == 0) begin
        send_gap <= $urandom_range(0, 7);
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid <= 1'b1;
        {in_ch.action, in_ch.job_id, in_ch.deadline, in_ch.service_time}
          <= pending_jobs[0];
      end
    end
  end

  // Monitor and receiver: compare each report with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_ticks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected tick report at %0t", $realtime);
        end else begin
          tick_word_t e, a;
          e = expected_ticks.pop_front();
          a = '{out_ch.ran_valid, out_ch.ran_job, out_ch.job_finished,
                out_ch.tick_time, out_ch.overflow_seen};
          if (a !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Tick report differs: expected %h actual %h", e, a);
          end
        end
      end
      if (hold_cycles > 0) out_ch.ready <= 1'b0;
      else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(0, 7);
        out_ch.ready <= 1'b0;
      end else out_ch.ready <= 1'b1;
    end
  end

  // Long receiver hold-off, counted in its own process.
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  task automatic wait_drained();
    while (pending_jobs.size() > 0 || expected_ticks.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // Random job sequence: mostly arrivals, with deadlines near current time unless noisy.
  task automatic add_random(int count, bit noisy);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 45) queue_job(make_tick());
      else begin
        logic [15:0] st, dl;
        st = (noisy || $urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
        dl = noisy ? 16'($urandom) : 16'(i / 2 + st + $urandom_range(0, 4));
        queue_job(make_job(8'($urandom), dl, st));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0; in_ch.valid = 1'b0; in_ch.action = 1'b0; in_ch.job_id = '0;
    in_ch.deadline = '0; in_ch.service_time = '0; out_ch.ready = 1'b0;
    q_len = 0; sched_time = '0; dropped_flag = 1'b0; mismatches = 0;
    send_idle_on = 1'b1; recv_idle_on = 1'b1; hold_cycles = 0; send_pause = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty tick, zero service time, extremes, equal laxities, zero laxity.
    queue_job(make_tick());
    queue_job(make_job(8'hFF, 16'hFFFF, 16'd0));
    queue_job(make_job(8'h00, 16'd0, 16'hFFFF));
    queue_job(make_job(8'h55, 16'd7, 16'd3));
    queue_job(make_job(8'hAA, 16'd7, 16'd3));
    queue_job(make_job(8'h12, 16'd5, 16'd1));
    for (int i = 0; i < 8; i++) queue_job(make_tick());
    // Fill past the queue depth to raise the overflow flag.
    for (int i = 0; i < 18; i++) queue_job(make_job(8'(i), 16'hFFFF, 16'd1));
    queue_job(make_tick());

    // Wait until all words are sent and all reports are in.
    wait_drained();

    // Long receiver stall while the sender keeps offering words.
    hold_cycles = 600;
    add_random(100, 1'b0);
    wait_drained();

    // Fresh-feeling random traffic; the queue may still hold long jobs.
    add_random(700, 1'b0);
    add_random(150, 1'b1);
    wait_drained();

    // Final part with no idling on either side.
    send_idle_on = 1'b0; recv_idle_on = 1'b0;
    add_random(170, 1'b0);
    wait_drained();

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end
endmodule

// File: filelist.f
sv/llf_pkg.sv
sv/llf_if.sv
sv/llf_datapath.sv
sv/llf_ctrl.sv
sv/least_laxity_first_scheduler_core.sv
tb/least_laxity_first_scheduler_core_tb.sv
